// ===== sv/cvm_pkg.sv =====
// ----------------------------------------------------------------------------
// cvm_pkg: shared types and constants of the cell voltage monitor
// Holds the full-scale reading and the control group of the counter bank.
// ----------------------------------------------------------------------------
package cvm_pkg;

  localparam int          VOLT_W   = 16;
  localparam logic [15:0] FULL16   = 16'hFFFF;

  // control of one counter read-modify-write step
  typedef struct packed {
    logic step;        // write back the counters of the current slot
    logic inc_plaus;   // plausibility check passed
    logic inc_tol;     // tolerated window check passed
  } cvm_bank_ctl_t;

endpackage

// ===== sv/cvm_counter_bank.sv =====
// ----------------------------------------------------------------------------
// cvm_counter_bank: per-cell event counter memories
// Two counter memories with registered read, valid bits cleared by reset and
// a saturating read-modify-write at the current slot.
// ----------------------------------------------------------------------------
module cvm_counter_bank
  import cvm_pkg::*;
#(
  parameter int DEPTH  = 192,
  parameter int ADDR_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  cvm_bank_ctl_t       ctl,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [VOLT_W-1:0]   plaus_count,
  output logic [VOLT_W-1:0]   tol_count
);

  logic [VOLT_W-1:0] mem_plaus [DEPTH];
  logic [VOLT_W-1:0] mem_tol   [DEPTH];
  logic [DEPTH-1:0]  vld;

  logic [VOLT_W-1:0] rd_plaus;
  logic [VOLT_W-1:0] rd_tol;
  logic              rd_vld;

  logic [VOLT_W-1:0] plaus_old;
  logic [VOLT_W-1:0] tol_old;
  logic              bypass;

  // a slot never written reads as zero
  assign plaus_old = rd_vld ? rd_plaus : '0;
  assign tol_old   = rd_vld ? rd_tol   : '0;

  assign plaus_count = (ctl.inc_plaus && plaus_old != FULL16) ? plaus_old + 1'b1 : plaus_old;
  assign tol_count   = (ctl.inc_tol   && tol_old   != FULL16) ? tol_old   + 1'b1 : tol_old;

  // forward the write when the prefetch hits the slot being written
  assign bypass = ctl.step && (rd_addr == wr_addr);

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      mem_plaus[wr_addr] <= plaus_count;
      mem_tol[wr_addr]   <= tol_count;
    end
    if (bypass) begin
      rd_plaus <= plaus_count;
      rd_tol   <= tol_count;
    end else begin
      rd_plaus <= mem_plaus[rd_addr];
      rd_tol   <= mem_tol[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.step) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= bypass ? 1'b1 : vld[rd_addr];
    end
  end

endmodule

// ===== sv/cvm_const_div.sv =====
// ----------------------------------------------------------------------------
// cvm_const_div: division by a build-time constant
// Exact floor division by multiplying with a rounded-up reciprocal; returns
// the low 16 bits of the quotient.
// ----------------------------------------------------------------------------
module cvm_const_div
  import cvm_pkg::*;
#(
  parameter int N = 20,
  parameter int D = 12
) (
  input  logic [N-1:0]      dividend,
  output logic [VOLT_W-1:0] quotient
);

  localparam int          L  = (D > 1) ? $clog2(D) : 0;
  localparam int          SH = N + L;
  localparam int          MW = N + 1;
  localparam int          PW = N + MW + VOLT_W;
  localparam logic [63:0] M  = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);

  logic [MW-1:0] recip;
  logic [PW-1:0] prod;

  assign recip    = M[MW-1:0];
  assign prod     = PW'(dividend) * PW'(recip);
  assign quotient = prod[SH +: VOLT_W];

endmodule

// ===== sv/cell_voltage_monitor.sv =====
// ----------------------------------------------------------------------------
// cell_voltage_monitor: per-cell window checks, event counters and pack stats
// Pipeline: three register stages (input, checked sample, result); m_tvalid
// rises once the sample reaches the result register.
// Throughput: one sample per cycle while m_tready keeps the output moving;
// set by the counter read-modify-write, whose read is prefetched one slot ahead.
// Reset: synchronous; counter valid bits clear at once, no clearing pass.
// Limit registers return to their open windows, scan restarts at cell 0.
// ----------------------------------------------------------------------------
module cell_voltage_monitor
  import cvm_pkg::*;
#(
  parameter int MODULES          = 16,
  parameter int CELLS_PER_MODULE = 12
) (
  input  logic         clk,
  input  logic         rst,
  // configuration write port
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // sample stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [15:0] cell reading
  input  logic         s_tuser,   // [0] charging
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] module_index, [4] cell_plausible, [5] cell_tolerated,
  // [21:6] plausible_count, [37:22] tolerated_count, [38] module_done,
  // [54:39] module_average, [78:55] pack_total, [94:79] pack_average,
  // [110:95] pack_max, [126:111] pack_min, [127] zero
  output logic [127:0] m_tdata,
  output logic         m_tlast    // scan_done
);

  localparam int CELL_TOTAL = MODULES * CELLS_PER_MODULE;
  localparam int SLOT_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;
  localparam int MPOS_W     = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int CPOS_W     = (CELLS_PER_MODULE > 1) ? $clog2(CELLS_PER_MODULE) : 1;
  localparam int MOD_W      = $clog2(CELLS_PER_MODULE * 65535 + 1);
  localparam int PACK_W     = $clog2(CELL_TOTAL * 65535 + 1);

  localparam logic [MPOS_W-1:0] MOD_LAST  = MPOS_W'(MODULES - 1);
  localparam logic [CPOS_W-1:0] CELL_LAST = CPOS_W'(CELLS_PER_MODULE - 1);

  localparam logic [2:0] REG_PLAUS_MIN = 3'd0;
  localparam logic [2:0] REG_PLAUS_MAX = 3'd1;
  localparam logic [2:0] REG_CHG_MIN   = 3'd2;
  localparam logic [2:0] REG_CHG_MAX   = 3'd3;
  localparam logic [2:0] REG_DIS_MIN   = 3'd4;
  localparam logic [2:0] REG_DIS_MAX   = 3'd5;

  // limit registers
  logic [15:0] plaus_min, plaus_max, chg_min, chg_max, dis_min, dis_max;

  // scan state
  logic [MPOS_W-1:0] module_pos;
  logic [CPOS_W-1:0] cell_pos;
  logic [SLOT_W-1:0] slot;
  logic [MOD_W-1:0]  module_sum;
  logic [PACK_W-1:0] pack_sum;
  logic [15:0]       running_max;
  logic [15:0]       running_min;

  // pipeline valids
  logic v1, v2, v3;
  logic accept, step, adv3;

  // stage 1: input register
  logic [15:0] cv1;
  logic        chg1;

  // stage 2: checked sample and running totals
  logic [3:0]        idx2;
  logic              plaus2, tol2, md2, sd2;
  logic [15:0]       pc2, tc2, max2, min2;
  logic [MOD_W-1:0]  msum2;
  logic [PACK_W-1:0] pack2;

  // stage 3: result register
  logic [127:0] out_data;
  logic         out_last;

  // combinational step logic
  logic              plaus, tol, mod_end, scan_end;
  logic [15:0]       lo, hi, max_new, min_new;
  logic [MOD_W-1:0]  msum_new;
  logic [PACK_W-1:0] pack_new;
  logic [SLOT_W-1:0] next_slot, rd_addr;
  logic [MPOS_W+3:0] mpos_ext;
  logic [PACK_W+23:0] pack_ext;
  logic [15:0]       plaus_count, tol_count, mod_avg, pack_avg;
  cvm_bank_ctl_t     bank_ctl;

  // ---------------------------------------------------------------------------
  // Handshake: each stage advances when the one after it is empty or moving.
  // The input register doubles as skid, so a sample is taken while a result
  // still waits downstream.
  // ---------------------------------------------------------------------------
  assign adv3     = v2 && (!v3 || m_tready);
  assign step     = v1 && (!v2 || adv3);
  assign s_tready = !v1 || step;
  assign accept   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Configuration: unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      plaus_min <= '0;
      plaus_max <= FULL16;
      chg_min   <= '0;
      chg_max   <= FULL16;
      dis_min   <= '0;
      dis_max   <= FULL16;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PLAUS_MIN: plaus_min <= cfg_data;
        REG_PLAUS_MAX: plaus_max <= cfg_data;
        REG_CHG_MIN:   chg_min   <= cfg_data;
        REG_CHG_MAX:   chg_max   <= cfg_data;
        REG_DIS_MIN:   dis_min   <= cfg_data;
        REG_DIS_MAX:   dis_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Window checks, both inclusive; an inverted window never passes.
  // ---------------------------------------------------------------------------
  assign lo    = chg1 ? chg_min : dis_min;
  assign hi    = chg1 ? chg_max : dis_max;
  assign plaus = (cv1 >= plaus_min) && (cv1 <= plaus_max);
  assign tol   = (cv1 >= lo) && (cv1 <= hi);

  assign mod_end  = (cell_pos == CELL_LAST);
  assign scan_end = mod_end && (module_pos == MOD_LAST);

  assign msum_new = module_sum + MOD_W'(cv1);
  assign pack_new = pack_sum + PACK_W'(msum_new);
  assign max_new  = (cv1 > running_max) ? cv1 : running_max;
  assign min_new  = (cv1 < running_min) ? cv1 : running_min;

  // Prefetch the next slot while stepping, otherwise keep reading this one.
  assign next_slot = scan_end ? '0 : slot + SLOT_W'(1);
  assign rd_addr   = step ? next_slot : slot;

  assign mpos_ext = (MPOS_W + 4)'(module_pos);

  assign bank_ctl.step      = step;
  assign bank_ctl.inc_plaus = plaus;
  assign bank_ctl.inc_tol   = tol;

  cvm_counter_bank #(
    .DEPTH  (CELL_TOTAL),
    .ADDR_W (SLOT_W)
  ) u_bank (
    .clk         (clk),
    .rst         (rst),
    .ctl         (bank_ctl),
    .wr_addr     (slot),
    .rd_addr     (rd_addr),
    .plaus_count (plaus_count),
    .tol_count   (tol_count)
  );

  // ---------------------------------------------------------------------------
  // Control state: valids, scan position and running totals.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      module_pos  <= '0;
      cell_pos    <= '0;
      slot        <= '0;
      module_sum  <= '0;
      pack_sum    <= '0;
      running_max <= '0;
      running_min <= FULL16;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (step) begin
        v1 <= 1'b0;
      end
      if (step) begin
        v2 <= 1'b1;
      end else if (adv3) begin
        v2 <= 1'b0;
      end
      if (adv3) begin
        v3 <= 1'b1;
      end else if (m_tready) begin
        v3 <= 1'b0;
      end

      if (step) begin
        slot <= next_slot;
        if (mod_end) begin
          // close the module; on a scan end restart the pack totals too
          module_sum <= '0;
          cell_pos   <= '0;
          if (scan_end) begin
            module_pos  <= '0;
            pack_sum    <= '0;
            running_max <= '0;
            running_min <= FULL16;
          end else begin
            module_pos  <= module_pos + MPOS_W'(1);
            pack_sum    <= pack_new;
            running_max <= max_new;
            running_min <= min_new;
          end
        end else begin
          cell_pos    <= cell_pos + CPOS_W'(1);
          module_sum  <= msum_new;
          running_max <= max_new;
          running_min <= min_new;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers of stages 1 and 2.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cv1  <= s_tdata;
      chg1 <= s_tuser;
    end
    if (step) begin
      idx2   <= mpos_ext[3:0];
      plaus2 <= plaus;
      tol2   <= tol;
      pc2    <= plaus_count;
      tc2    <= tol_count;
      md2    <= mod_end;
      sd2    <= scan_end;
      msum2  <= msum_new;
      pack2  <= pack_new;
      max2   <= max_new;
      min2   <= min_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: averages by constant reciprocal; zero the fields not on an end.
  // ---------------------------------------------------------------------------
  cvm_const_div #(
    .N (MOD_W),
    .D (CELLS_PER_MODULE)
  ) u_mod_div (
    .dividend (msum2),
    .quotient (mod_avg)
  );

  cvm_const_div #(
    .N (PACK_W),
    .D (CELL_TOTAL)
  ) u_pack_div (
    .dividend (pack2),
    .quotient (pack_avg)
  );

  assign pack_ext = (PACK_W + 24)'(pack2);

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_data <= {1'b0,
                   sd2 ? min2           : 16'h0000,
                   sd2 ? max2           : 16'h0000,
                   sd2 ? pack_avg       : 16'h0000,
                   sd2 ? pack_ext[23:0] : 24'h000000,
                   md2 ? mod_avg        : 16'h0000,
                   md2, tc2, pc2, tol2, plaus2, idx2};
      out_last <= sd2;
    end
  end

  assign m_tvalid = v3;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_scan_end_closes_module: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[38])
    else $error("scan end without module end");

  a_pack_fields_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[126:55] == '0)
    else $error("pack fields set off a scan end");

  a_slot_tracks_position: assert property (@(posedge clk) disable iff (rst)
    slot == SLOT_W'(int'(module_pos) * CELLS_PER_MODULE + int'(cell_pos)))
    else $error("slot out of step with scan position");

  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    step && scan_end |=> pack_sum == '0 && running_min == FULL16 && slot == '0)
    else $error("totals not restarted after scan end");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the cell voltage monitor
// Streams cell samples through the block with random gaps and back-pressure,
// predicts every report from a cycle-free model of the scan, the window
// checks and the per-cell event counters, and compares each result transfer
// with its prediction as a whole, pad bit included. Limit registers change only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top
  import cvm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MODULES        = 16;
  localparam int CELLS          = 12;
  localparam int CELL_TOTAL     = MODULES * CELLS;
  localparam int RESULT_LATENCY = 3;
  localparam int IDLE_PERCENT   = 34;

  // limit register indexes; 6 and 7 are unmapped and must be ignored
  localparam logic [2:0] REG_PLAUS_MIN = 3'd0;
  localparam logic [2:0] REG_PLAUS_MAX = 3'd1;
  localparam logic [2:0] REG_CHG_MIN   = 3'd2;
  localparam logic [2:0] REG_CHG_MAX   = 3'd3;
  localparam logic [2:0] REG_DIS_MIN   = 3'd4;
  localparam logic [2:0] REG_DIS_MAX   = 3'd5;
  localparam logic [2:0] REG_SPARE_A   = 3'd6;
  localparam logic [2:0] REG_SPARE_B   = 3'd7;

  // one sample on the input stream
  typedef struct packed {
    logic        charging;
    logic [15:0] volt;
  } cell_sample_t;

  // one report, laid out as {m_tlast, m_tdata[126:0]}
  typedef struct packed {
    logic        scan_done;
    logic [15:0] pack_min;
    logic [15:0] pack_max;
    logic [15:0] pack_average;
    logic [23:0] pack_total;
    logic [15:0] module_average;
    logic        module_done;
    logic [15:0] tol_count;
    logic [15:0] plaus_count;
    logic        tolerated;
    logic        plausible;
    logic [3:0]  module_index;
  } cell_report_t;

  logic         clk;
  logic         rst;
  logic         cfg_wen;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [15:0]  s_tdata;    // [15:0] cell reading
  logic         s_tuser;    // [0] charging
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;    // module_index .. pack_min, see cell_report_t
  logic         m_tlast;    // scan_done

  cell_voltage_monitor #(
    .MODULES         (MODULES),
    .CELLS_PER_MODULE(CELLS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // stimulus and expectations
  cell_sample_t sample_q[$];
  cell_report_t report_q[$];
  cell_sample_t next_sample;
  bit           steady;       // 1 disables idling on both sides

  // predictor state: scan position, running sums, extremes, event counters
  logic [15:0]  limit_regs [0:5];
  int unsigned  scan_module;
  int unsigned  scan_cell;
  int unsigned  module_acc;
  int unsigned  pack_acc;
  logic [15:0]  peak_volt;
  logic [15:0]  floor_volt;
  logic [15:0]  plaus_hits [0:CELL_TOTAL-1];
  logic [15:0]  tol_hits   [0:CELL_TOTAL-1];

  // run statistics
  int mismatches;
  int samples_sent;
  int reports_checked;
  int scans_seen;
  int limit_settings;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous cap on the whole run
  initial begin
    #500us;
    $display("FAIL");
    $finish;
  end

  // Advance the scan model by one sample and return the report it causes.
  function automatic cell_report_t predict_cell_report(input logic [15:0] volt,
                                                        input logic charging);
    cell_report_t r;
    int unsigned  slot;
    int unsigned  quot;
    logic [15:0]  lo;
    logic [15:0]  hi;
    r    = '0;
    slot = scan_module * CELLS + scan_cell;
    lo   = charging ? limit_regs[REG_CHG_MIN] : limit_regs[REG_DIS_MIN];
    hi   = charging ? limit_regs[REG_CHG_MAX] : limit_regs[REG_DIS_MAX];
    r.module_index = scan_module[3:0];
    // inverted windows fall out naturally: no value satisfies both bounds
    r.plausible = (volt >= limit_regs[REG_PLAUS_MIN]) && (volt <= limit_regs[REG_PLAUS_MAX]);
    r.tolerated = (volt >= lo) && (volt <= hi);
    // counters stick at full scale
    if (r.plausible && plaus_hits[slot] != FULL16) plaus_hits[slot] = plaus_hits[slot] + 16'd1;
    if (r.tolerated && tol_hits[slot] != FULL16) tol_hits[slot] = tol_hits[slot] + 16'd1;
    r.plaus_count = plaus_hits[slot];
    r.tol_count   = tol_hits[slot];
    module_acc = module_acc + 32'(volt);
    if (volt > peak_volt) peak_volt = volt;
    if (volt < floor_volt) floor_volt = volt;
    r.module_done = (scan_cell == CELLS - 1);
    r.scan_done   = r.module_done && (scan_module == MODULES - 1);
    if (r.module_done) begin
      quot             = module_acc / CELLS;
      r.module_average = quot[15:0];
      pack_acc         = pack_acc + module_acc;
      module_acc       = 0;
      scan_cell        = 0;
      if (r.scan_done) begin
        quot           = pack_acc / CELL_TOTAL;
        r.pack_total   = pack_acc[23:0];
        r.pack_average = quot[15:0];
        r.pack_max     = peak_volt;
        r.pack_min     = floor_volt;
        // wrap to the first cell and reopen the extremes
        pack_acc    = 0;
        peak_volt   = 16'h0000;
        floor_volt  = FULL16;
        scan_module = 0;
      end else begin
        scan_module = scan_module + 1;
      end
    end else begin
      scan_cell = scan_cell + 1;
    end
    return r;
  endfunction

  function automatic string report_text(input cell_report_t r);
    return $sformatf({"mod=%0d pl=%b tl=%b pc=%0d tc=%0d md=%b mavg=%0d ",
                      "sd=%b tot=%0d pavg=%0d max=%0d min=%0d"},
                     r.module_index, r.plausible, r.tolerated, r.plaus_count,
                     r.tol_count, r.module_done, r.module_average, r.scan_done,
                     r.pack_total, r.pack_average, r.pack_max, r.pack_min);
  endfunction

  // Input side: predict on every accepted transfer, then present the next
  // sample or idle. s_tvalid gets at most one assignment per edge.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        report_q.push_back(predict_cell_report(s_tdata, s_tuser));
        samples_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_sample = sample_q.pop_front();
          s_tdata  <= next_sample.volt;
          s_tuser  <= next_sample.charging;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each result transfer against the oldest prediction,
  // and stall at random.
  always @(posedge clk) begin : result_check
    cell_report_t got;
    cell_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata[126:0]};
        if (m_tlast) scans_seen++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: result with no pending sample: %s", $realtime,
                     report_text(got));
        end else begin
          want = report_q.pop_front();
          reports_checked++;
          if (got !== want || m_tdata[127] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR %0t: report %0d differs (pad bit %b)", $realtime,
                       reports_checked, m_tdata[127]);
              $display("  want %s", report_text(want));
              $display("  got  %s", report_text(got));
            end
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Write one limit register and mirror it in the predictor; unmapped
  // indexes leave the mirror untouched.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx <= REG_DIS_MAX) limit_regs[idx] = value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [15:0] pmin, input logic [15:0] pmax,
                            input logic [15:0] cmin, input logic [15:0] cmax,
                            input logic [15:0] dmin, input logic [15:0] dmax);
    write_reg(REG_PLAUS_MIN, pmin);
    write_reg(REG_PLAUS_MAX, pmax);
    write_reg(REG_CHG_MIN, cmin);
    write_reg(REG_CHG_MAX, cmax);
    write_reg(REG_DIS_MIN, dmin);
    write_reg(REG_DIS_MAX, dmax);
    limit_settings++;
  endtask

  // Draw three windows of random position and width up to span; some come
  // out inverted when asked.
  task automatic set_random_limits(input bit allow_inverted, input int span);
    int lo [0:2];
    int hi [0:2];
    int tmp;
    for (int w = 0; w < 3; w++) begin
      lo[w] = $urandom_range(65535);
      hi[w] = lo[w] + $urandom_range(span);
      if (hi[w] > 65535) hi[w] = 65535;
      if (allow_inverted && $urandom_range(3) == 0) begin
        tmp   = lo[w];
        lo[w] = hi[w];
        hi[w] = tmp;
      end
    end
    set_limits(16'(lo[0]), 16'(hi[0]), 16'(lo[1]), 16'(hi[1]),
               16'(lo[2]), 16'(hi[2]));
  endtask

  task automatic add_sample(input logic [15:0] volt, input logic charging);
    cell_sample_t s;
    s.charging = charging;
    s.volt     = volt;
    sample_q.push_back(s);
  endtask

  // Pick a reading: often near the bounds of one live window, else inside it,
  // at a full-scale extreme or uniform over the whole range.
  function automatic logic [15:0] pick_voltage(input logic charging);
    int lo;
    int hi;
    int anchor;
    if ($urandom_range(2) == 0) begin
      lo = int'(limit_regs[REG_PLAUS_MIN]);
      hi = int'(limit_regs[REG_PLAUS_MAX]);
    end else if (charging) begin
      lo = int'(limit_regs[REG_CHG_MIN]);
      hi = int'(limit_regs[REG_CHG_MAX]);
    end else begin
      lo = int'(limit_regs[REG_DIS_MIN]);
      hi = int'(limit_regs[REG_DIS_MAX]);
    end
    case ($urandom_range(9))
      0: anchor = $urandom_range(1) ? 65535 : 0;
      1, 2, 3, 4: begin
        anchor = ($urandom_range(1) ? lo : hi) + $urandom_range(4) - 2;
        if (anchor < 0) anchor = 0;
        if (anchor > 65535) anchor = 65535;
      end
      5, 6: anchor = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(65535);
      default: anchor = $urandom_range(65535);
    endcase
    return anchor[15:0];
  endfunction

  // Queue count random samples; high_bias pushes most readings near full
  // scale so the pack total reaches its top bits.
  task automatic add_random(input int count, input bit high_bias);
    logic charging;
    for (int k = 0; k < count; k++) begin
      charging = 1'($urandom_range(1));
      if (high_bias && $urandom_range(3) != 0)
        add_sample(16'($urandom_range(65535, 49152)), charging);
      else
        add_sample(pick_voltage(charging), charging);
    end
  endtask

  // Hold until every queued sample went in and every report came back,
  // then let the pipeline settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || s_tvalid || report_q.size() != 0);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = REG_PLAUS_MIN;
    cfg_data  = 16'h0000;
    s_tvalid  = 1'b0;
    s_tdata   = 16'h0000;
    s_tuser   = 1'b0;
    m_tready  = 1'b0;
    steady    = 1'b0;
    mismatches      = 0;
    samples_sent    = 0;
    reports_checked = 0;
    scans_seen      = 0;
    limit_settings  = 1;

    // predictor starts from the reset state: open windows, cleared counters
    limit_regs[REG_PLAUS_MIN] = 16'h0000;
    limit_regs[REG_PLAUS_MAX] = FULL16;
    limit_regs[REG_CHG_MIN]   = 16'h0000;
    limit_regs[REG_CHG_MAX]   = FULL16;
    limit_regs[REG_DIS_MIN]   = 16'h0000;
    limit_regs[REG_DIS_MAX]   = FULL16;
    scan_module = 0;
    scan_cell   = 0;
    module_acc  = 0;
    pack_acc    = 0;
    peak_volt   = 16'h0000;
    floor_volt  = FULL16;
    for (int c = 0; c < CELL_TOTAL; c++) begin
      plaus_hits[c] = 16'h0000;
      tol_hits[c]   = 16'h0000;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: full-scale and alternating-bit readings in the open windows.
    add_sample(16'h0000, 1'b0);
    add_sample(16'hFFFF, 1'b1);
    add_sample(16'h5555, 1'b0);
    add_sample(16'hAAAA, 1'b1);
    add_sample(16'h0001, 1'b1);
    add_sample(16'hFFFE, 1'b0);
    wait_idle();

    // Directed: readings on and just outside each inclusive bound.
    set_limits(16'd1000, 16'd4000, 16'd2000, 16'd3000, 16'd1500, 16'd3500);
    // unmapped indexes must not disturb the live limits
    write_reg(REG_SPARE_A, 16'h0000);
    write_reg(REG_SPARE_B, 16'hFFFF);
    add_sample(16'd999, 1'b1);
    add_sample(16'd1000, 1'b1);
    add_sample(16'd4000, 1'b1);
    add_sample(16'd4001, 1'b1);
    add_sample(16'd1999, 1'b1);
    add_sample(16'd2000, 1'b1);
    add_sample(16'd3000, 1'b1);
    add_sample(16'd3001, 1'b1);
    add_sample(16'd1499, 1'b0);
    add_sample(16'd1500, 1'b0);
    add_sample(16'd3500, 1'b0);
    add_sample(16'd3501, 1'b0);
    wait_idle();

    // Directed: inverted windows reject everything.
    set_limits(16'd5000, 16'd4000, 16'hFFFF, 16'h0000, 16'd1, 16'd0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'd4000, 1'b1);
    add_sample(16'd4500, 1'b0);
    add_sample(16'd5000, 1'b1);
    add_sample(16'hFFFF, 1'b0);
    wait_idle();

    // Random: open windows again.
    set_limits(16'h0000, FULL16, 16'h0000, FULL16, 16'h0000, FULL16);
    add_random(300, 1'b0);
    wait_idle();

    // Random: single-point windows at the bottom of the range.
    set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_random(200, 1'b0);
    wait_idle();

    // Random: single-point windows at full scale.
    set_limits(FULL16, FULL16, FULL16, FULL16, FULL16, FULL16);
    add_random(200, 1'b0);
    wait_idle();

    // Random: wide windows with both sides streaming back to back.
    set_random_limits(1'b0, 40000);
    steady = 1'b1;
    add_random(400, 1'b0);
    wait_idle();
    steady = 1'b0;

    // Random: readings near full scale, windows possibly inverted.
    set_random_limits(1'b1, 30000);
    add_random(400, 1'b1);
    wait_idle();

    // Random: narrow windows, bounds hit often.
    set_random_limits(1'b1, 64);
    add_random(300, 1'b0);
    wait_idle();

    $display("Streamed %0d samples over %0d limit settings; %0d reports checked, %0d full scans.",
             samples_sent, limit_settings, reports_checked, scans_seen);
    $display("Mismatches: %0d, reports still pending: %0d.", mismatches, report_q.size());
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
